// ----- rtl/relay_text_command_decoder_assert.svh -----
// ---------------------------------------------------------------------------
// relay text command decoder assertion macros
// concurrent property wrappers used by relay_text_command_decoder.sv
// ---------------------------------------------------------------------------
`ifndef RELAY_TEXT_COMMAND_DECODER_ASSERT_SVH
`define RELAY_TEXT_COMMAND_DECODER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RTCD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RTCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rtcd_pkg.sv -----
// ---------------------------------------------------------------------------
// rtcd_pkg
// shared constants, keyword table and types of the relay command decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtcd_pkg;

    localparam int BUFFER_BYTES    = 32;
    localparam int PARAM_MAX_BYTES = 28;
    localparam int WINDOW_LEN      = 19;
    localparam int NUM_KEYWORDS    = 6;
    localparam int POS_W           = $clog2(BUFFER_BYTES + 1);
    localparam int CODE_W          = 3;
    localparam int RELAYS          = 4;

    // command codes, also the keyword priority order
    localparam logic [CODE_W-1:0] CMD_RELAY_ON  = 3'd0;
    localparam logic [CODE_W-1:0] CMD_RELAY_OFF = 3'd1;
    localparam logic [CODE_W-1:0] CMD_LED_TEST  = 3'd2;
    localparam logic [CODE_W-1:0] CMD_ALL_ON    = 3'd3;
    localparam logic [CODE_W-1:0] CMD_ALL_OFF   = 3'd4;
    localparam logic [CODE_W-1:0] CMD_NURSE     = 3'd5;

    localparam logic [7:0] CHAR_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE = 8'h5D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // keywords right aligned: last character in bits [7:0], zero filled above
    localparam int KW_BITS = (WINDOW_LEN + 1) * 8;
    localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        {"TURN_", "RELAY_ON"},
        {"TURN_", "RELAY_OFF"},
        {"BUILT_IN_", "LED_TEST"},
        {"TURN_", "EVERYTHING_ON"},
        {"TURN_", "EVERYTHING_OFF"},
        {"CALL_", "NURSE"}
    };
    localparam int KW_LEN [NUM_KEYWORDS] = '{13, 14, 17, 18, 19, 10};

    typedef logic [7:0]              byte_t;
    typedef logic [NUM_KEYWORDS-1:0] kw_vec_t;
    typedef logic [POS_W-1:0]        pos_t;

    // per-cell reference characters, one per keyword, and which ones count
    typedef struct packed {
        byte_t [NUM_KEYWORDS-1:0] ch;
        kw_vec_t                  care;
    } cell_ref_t;

    // per-beat control shared by the window cells and the parameter tracker
    typedef struct packed {
        logic take;
        logic clear;
    } step_ctrl_t;

    // bracket and parameter state after a beat
    typedef struct packed {
        logic  open_seen;
        pos_t  open_pos;
        logic  close_seen;
        pos_t  close_pos;
        byte_t value;
    } param_state_t;

endpackage

// ----- rtl/relay_text_command_decoder.sv -----
// a result beat appears in the cycle after the beat flagged tlast is accepted
// throughput: one command byte per cycle; a result beat per command
// the keyword compare runs across the incoming byte and a row of 18 window cells in parallel
// input stalls only while a result beat waits in the output register
// reset (rst_n low, asynchronous) clears the window, parser state and relays
// ---------------------------------------------------------------------------
// relay_text_command_decoder
// streaming text command parser that drives four relay bits
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "relay_text_command_decoder_assert.svh"

module relay_text_command_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] cmd_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [2:0] command_code, [3] parse_ok,
                                        // [11:4] relay_index, [15:12] relay_state
);

    localparam int NKW   = rtcd_pkg::NUM_KEYWORDS;
    localparam int WL    = rtcd_pkg::WINDOW_LEN;
    // the incoming byte is the newest window entry, the cells hold the rest
    localparam int NCELL = WL - 1;

    // ------------------------------------------------------------------
    // beat handshake and per-beat control
    // ------------------------------------------------------------------
    logic                 in_beat;
    logic                 last_beat;
    rtcd_pkg::step_ctrl_t ctrl;
    rtcd_pkg::pos_t       pos_reg;
    rtcd_pkg::pos_t       pos_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;

    // the output register frees up in the same cycle it is drained
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign last_beat     = in_beat && s_axis_tlast;

    // bytes beyond the buffer are dropped, tlast is still honored
    assign ctrl.take  = in_beat && (pos_reg < rtcd_pkg::POS_W'(rtcd_pkg::BUFFER_BYTES));
    assign ctrl.clear = last_beat;

    always_comb
    begin
        pos_next = pos_reg;
        if (ctrl.clear)
        begin
            pos_next = '0;
        end
        else if (ctrl.take)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // window: a row of cells, cell 0 holds the newest stored byte
    // cell j is compared against the keyword character at position j+1
    // from the end, since the incoming byte takes position 0
    // ------------------------------------------------------------------
    rtcd_pkg::byte_t     win [NCELL];
    rtcd_pkg::kw_vec_t   cell_eq [NCELL];
    rtcd_pkg::cell_ref_t cell_ref [NCELL];
    logic [NCELL-1:0]    eq_col [NKW];

    genvar j, k;
    generate
        for (j = 0; j < NCELL; j++)
        begin : g_cell
            rtcd_pkg::byte_t feed;

            if (j == 0)
            begin : g_head
                assign feed = s_axis_tdata;
            end
            else
            begin : g_body
                assign feed = win[j-1];
            end

            for (k = 0; k < NKW; k++)
            begin : g_ref
                assign cell_ref[j].ch[k]   = rtcd_pkg::KW_TEXT[k][8*(j+1) +: 8];
                assign cell_ref[j].care[k] = ((j + 1) < rtcd_pkg::KW_LEN[k]);
                assign eq_col[k][j]        = cell_eq[j][k];
            end

            rtcd_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .byte_in   (feed),
                .match_ref (cell_ref[j]),
                .byte_out  (win[j]),
                .eq        (cell_eq[j])
            );
        end
    endgenerate

    // keyword hit: newest byte matches the last character, all cells agree
    rtcd_pkg::kw_vec_t hit;
    rtcd_pkg::kw_vec_t found_reg;
    rtcd_pkg::kw_vec_t found_after;
    rtcd_pkg::kw_vec_t found_next;

    generate
        for (k = 0; k < NKW; k++)
        begin : g_hit
            assign hit[k] = (s_axis_tdata == rtcd_pkg::KW_TEXT[k][7:0]) && (&eq_col[k]);
        end
    endgenerate

    assign found_after = found_reg | (ctrl.take ? hit : '0);
    assign found_next  = ctrl.clear ? '0 : found_after;

    // ------------------------------------------------------------------
    // bracket and parameter tracking
    // ------------------------------------------------------------------
    rtcd_pkg::param_state_t pst;

    rtcd_param u_param
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cmd_byte (s_axis_tdata),
        .pos      (pos_reg),
        .after    (pst)
    );

    // ------------------------------------------------------------------
    // command resolution on the last beat
    // ------------------------------------------------------------------
    logic [rtcd_pkg::CODE_W-1:0] win_code;
    logic                        any_found;
    logic                        param_ok;
    rtcd_pkg::pos_t              span;
    logic [rtcd_pkg::RELAYS-1:0] relay_reg;
    logic [rtcd_pkg::RELAYS-1:0] relay_next;
    logic [rtcd_pkg::RELAYS-1:0] relay_new;
    logic [rtcd_pkg::RELAYS-1:0] relay_mask;
    logic                        idx_in_range;
    logic                        res_ok;
    rtcd_pkg::byte_t             res_idx;

    // lowest-numbered keyword wins
    always_comb
    begin
        win_code = rtcd_pkg::CMD_RELAY_ON;
        for (int n = NKW - 1; n >= 0; n--)
        begin
            if (found_after[n])
            begin
                win_code = rtcd_pkg::CODE_W'(n);
            end
        end
    end

    assign any_found = |found_after;

    // close must follow open with at most the maximum byte count between
    assign span     = pst.close_pos - pst.open_pos;
    assign param_ok = pst.open_seen && pst.close_seen && (pst.close_pos > pst.open_pos)
                   && ({1'b0, span} <= (rtcd_pkg::POS_W + 1)'(rtcd_pkg::PARAM_MAX_BYTES + 1));

    assign idx_in_range = (pst.value[7:2] == '0);
    assign relay_mask   = idx_in_range ? (rtcd_pkg::RELAYS'(1) << pst.value[1:0]) : '0;

    always_comb
    begin
        res_ok    = 1'b0;
        res_idx   = '0;
        relay_new = relay_reg;
        if (any_found)
        begin
            priority if ((win_code == rtcd_pkg::CMD_RELAY_ON)
                      || (win_code == rtcd_pkg::CMD_RELAY_OFF))
            begin
                if (param_ok)
                begin
                    res_ok  = 1'b1;
                    res_idx = pst.value;
                    if (win_code == rtcd_pkg::CMD_RELAY_ON)
                    begin
                        relay_new = relay_reg | relay_mask;
                    end
                    else
                    begin
                        relay_new = relay_reg & ~relay_mask;
                    end
                end
            end
            else if (win_code == rtcd_pkg::CMD_ALL_ON)
            begin
                res_ok    = 1'b1;
                relay_new = '1;
            end
            else if (win_code == rtcd_pkg::CMD_ALL_OFF)
            begin
                res_ok    = 1'b1;
                relay_new = '0;
            end
            else
            begin
                // led test and nurse: pulses not driven here, relays kept
                res_ok = 1'b1;
            end
        end
    end

    assign relay_next = last_beat ? relay_new : relay_reg;

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [rtcd_pkg::CODE_W-1:0] code_reg;
    logic                        ok_reg;
    rtcd_pkg::byte_t             idx_reg;
    logic [rtcd_pkg::RELAYS-1:0] state_reg;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (last_beat)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            found_reg   <= '0;
            relay_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            found_reg   <= found_next;
            relay_reg   <= relay_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, loaded only with a last beat
    always_ff @(posedge clk)
    begin
        if (last_beat)
        begin
            code_reg  <= any_found ? win_code : rtcd_pkg::CMD_RELAY_ON;
            ok_reg    <= res_ok;
            idx_reg   <= res_idx;
            state_reg <= relay_new;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {state_reg, idx_reg, ok_reg, code_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `RTCD_ASSERT_NEXT(a_clear_after_last, clk, rst_n, last_beat,
        (pos_reg == '0) && (found_reg == '0), "command state not cleared after last beat")
    `RTCD_ASSERT_NEXT(a_result_after_last, clk, rst_n, last_beat, m_valid_reg,
        "no result beat after last command byte")
    `RTCD_ASSERT_SAME(a_pos_bounded, clk, rst_n, 1'b1,
        pos_reg <= rtcd_pkg::POS_W'(rtcd_pkg::BUFFER_BYTES), "byte position past buffer size")
    `RTCD_ASSERT_SAME(a_code_legal, clk, rst_n, m_valid_reg,
        code_reg <= rtcd_pkg::CMD_NURSE, "command code out of range")
    `RTCD_ASSERT_SAME(a_idx_needs_ok, clk, rst_n, m_valid_reg && !ok_reg,
        idx_reg == '0, "relay index set without a parsed parameter")

endmodule

// ----- rtl/rtcd_cell.sv -----
// ---------------------------------------------------------------------------
// rtcd_cell
// one byte of the sliding window with its keyword character compares
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtcd_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rtcd_pkg::step_ctrl_t ctrl,
    input  rtcd_pkg::byte_t      byte_in,
    input  rtcd_pkg::cell_ref_t  match_ref,
    output rtcd_pkg::byte_t      byte_out,
    output rtcd_pkg::kw_vec_t    eq
);

    rtcd_pkg::byte_t byte_reg;
    rtcd_pkg::byte_t byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = '0;
        end
        else if (ctrl.take)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // positions beyond a keyword's length always agree
    always_comb
    begin
        for (int k = 0; k < rtcd_pkg::NUM_KEYWORDS; k++)
        begin
            eq[k] = !match_ref.care[k] || (byte_reg == match_ref.ch[k]);
        end
    end

    assign byte_out = byte_reg;

endmodule

// ----- rtl/rtcd_param.sv -----
// ---------------------------------------------------------------------------
// rtcd_param
// bracket position tracker and decimal parameter accumulator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtcd_param
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rtcd_pkg::step_ctrl_t   ctrl,
    input  rtcd_pkg::byte_t        cmd_byte,
    input  rtcd_pkg::pos_t         pos,
    output rtcd_pkg::param_state_t after
);

    rtcd_pkg::param_state_t st_reg;
    rtcd_pkg::param_state_t st_next;
    logic                   done_reg;
    logic                   done_after;
    logic                   done_next;
    logic                   is_digit;
    rtcd_pkg::byte_t        digit;

    assign is_digit = (cmd_byte >= rtcd_pkg::CHAR_ZERO) && (cmd_byte <= rtcd_pkg::CHAR_NINE);
    assign digit    = cmd_byte - rtcd_pkg::CHAR_ZERO;

    always_comb
    begin
        after      = st_reg;
        done_after = done_reg;
        if (ctrl.take)
        begin
            // digits count only after an earlier open bracket
            if (st_reg.open_seen && !done_reg)
            begin
                if (is_digit)
                begin
                    // value * 10 + digit, modulo 256
                    after.value = (st_reg.value << 3) + (st_reg.value << 1) + digit;
                end
                else
                begin
                    done_after = 1'b1;
                end
            end
            if ((cmd_byte == rtcd_pkg::CHAR_OPEN) && !st_reg.open_seen)
            begin
                after.open_seen = 1'b1;
                after.open_pos  = pos;
            end
            if ((cmd_byte == rtcd_pkg::CHAR_CLOSE) && !st_reg.close_seen)
            begin
                after.close_seen = 1'b1;
                after.close_pos  = pos;
            end
        end
    end

    always_comb
    begin
        st_next   = after;
        done_next = done_after;
        if (ctrl.clear)
        begin
            st_next   = '0;
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

endmodule
